// ===== sv/bb3_pkg.sv =====
`default_nettype none

package bb3_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int PIX_W = 24;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int X_W = 13;
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int FIFO_DEPTH = 4;

	localparam int FW_W = 12;
	localparam int FH_W = 13;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 12'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic valid;
		logic [2:0] row_mask;
		logic [2:0] col_mask;
		logic run_end;
		logic frame_end;
	} emit_req_t;

	typedef struct packed {
		logic valid;
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
		logic [CNT_W-1:0] count;
		logic run_end;
		logic frame_end;
	} sum_t;

	typedef struct packed {
		logic valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic run_end;
		logic frame_end;
	} result_t;

	// Rounded-up reciprocal of 2*count, scaled by 2**RECIP_SHIFT.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		unique case (count)
			4'd1: m = 20'd524288;
			4'd2: m = 20'd262144;
			4'd3: m = 20'd174763;
			4'd4: m = 20'd131072;
			4'd6: m = 20'd87382;
			4'd9: m = 20'd58255;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/bb3_ram.sv =====
`default_nettype none

module bb3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bb3_window.sv =====
`default_nettype none

module bb3_window (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic shift_en,
	input wire bb3_pkg::pixel_t above,
	input wire bb3_pkg::pixel_t mid,
	input wire bb3_pkg::pixel_t px,
	input wire bb3_pkg::emit_req_t req,
	output bb3_pkg::sum_t sum_s1
);

	import bb3_pkg::*;

	pixel_t win_q [3][3];
	sum_t sum_d;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= above;
			win_q[1][2] <= mid;
			win_q[2][2] <= px;
		end
	end

	always_comb begin
		logic [1:0] nr;
		logic [1:0] nc;
		sum_d = '0;
		nr = 2'($countones(req.row_mask));
		nc = 2'($countones(req.col_mask));
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (req.row_mask[r] && req.col_mask[k]) begin
					sum_d.sum_r = sum_d.sum_r + SUM_W'(win_q[r][k][23:16]);
					sum_d.sum_g = sum_d.sum_g + SUM_W'(win_q[r][k][15:8]);
					sum_d.sum_b = sum_d.sum_b + SUM_W'(win_q[r][k][7:0]);
				end
			end
		end
		sum_d.count = CNT_W'(nr) * CNT_W'(nc);
		sum_d.valid = req.valid;
		sum_d.run_end = req.run_end;
		sum_d.frame_end = req.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s1 <= '0;
		end else begin
			sum_s1 <= sum_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bb3_mean.sv =====
`default_nettype none

module bb3_mean (
	input wire logic clk,
	input wire logic arst_n,
	input wire bb3_pkg::sum_t sum_s1,
	output bb3_pkg::result_t res_s2
);

	import bb3_pkg::*;

	localparam int PROD_W = X_W + RECIP_W;

	logic [RECIP_W-1:0] m;
	logic [X_W-1:0] x_r;
	logic [X_W-1:0] x_g;
	logic [X_W-1:0] x_b;
	logic [PROD_W-1:0] p_r;
	logic [PROD_W-1:0] p_g;
	logic [PROD_W-1:0] p_b;

	always_comb begin
		m = recip(sum_s1.count);
		x_r = X_W'({sum_s1.sum_r, 1'b0}) + X_W'(sum_s1.count);
		x_g = X_W'({sum_s1.sum_g, 1'b0}) + X_W'(sum_s1.count);
		x_b = X_W'({sum_s1.sum_b, 1'b0}) + X_W'(sum_s1.count);
		p_r = PROD_W'(x_r) * PROD_W'(m);
		p_g = PROD_W'(x_g) * PROD_W'(m);
		p_b = PROD_W'(x_b) * PROD_W'(m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2.valid <= sum_s1.valid;
			res_s2.red <= p_r[RECIP_SHIFT +: 8];
			res_s2.green <= p_g[RECIP_SHIFT +: 8];
			res_s2.blue <= p_b[RECIP_SHIFT +: 8];
			res_s2.run_end <= sum_s1.run_end;
			res_s2.frame_end <= sum_s1.frame_end;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bb3_ofifo.sv =====
`default_nettype none

module bb3_ofifo #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bb3_pkg::result_t push,
	output logic out_valid,
	input wire logic out_ready,
	output bb3_pkg::result_t out_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	import bb3_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	result_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;
	logic pop;

	assign out_valid = (count_q != '0);
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/box_blur_3x3_rgb_unit.sv =====
// 3x3 box blur over RGB rows, two rows above held in one line-buffer RAM.
// Each taken pixel passes the RAM read and write-back state, then one window-sum state per result;
// an ignored tick leaves the unit idle. A new pixel is taken only in idle, with queue room.
// Each result passes the window-sum, mean and output-queue registers before m_axis_tvalid.
// Reset clears counters, control state and the output queue; line-buffer contents are
// undefined until written and never reach a result.
`default_nettype none

module box_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [23:0] s_axis_tdata, // in_red, in_green, in_blue
	input wire logic s_axis_tuser, // kind
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // out_red, out_green, out_blue
	output logic m_axis_tlast,
	output logic m_axis_tuser, // frame_end
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [bb3_pkg::APB_AW-1:0] paddr,
	input wire logic [bb3_pkg::APB_DW-1:0] pwdata,
	output logic [bb3_pkg::APB_DW-1:0] prdata,
	output logic pready
);

	import bb3_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int QCW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EMIT0 = 4'b0100,
		ST_EMIT1 = 4'b1000
	} state_t;

	state_t state_q;
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [CW-1:0] col_q;
	logic [FH_W-1:0] row_q;

	logic [CW-1:0] addr_q;
	pixel_t px_q;
	logic e0_q;
	logic e1_q;
	logic lo_skip_q;
	logic w1_q;
	logic top_ok_q;
	logic bot_ok_q;

	logic [WW-1:0] w_eff;
	logic [FH_W-1:0] h_eff;
	logic cfg_wr;
	logic accept;
	logic drain;
	logic take;
	logic col_last;
	logic [2*PIX_W-1:0] ram_rdata;
	emit_req_t req;
	sum_t sum_s1;
	result_t res_s2;
	result_t out_res;
	logic [QCW-1:0] q_count;
	logic [QCW:0] q_used;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? APB_DW'(frame_height_q)
		: APB_DW'(frame_width_q);

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end

	assign q_used = (QCW+1)'(q_count) + (QCW+1)'(sum_s1.valid) + (QCW+1)'(res_s2.valid);
	assign s_axis_tready = (state_q == ST_IDLE) && (q_used <= (QCW+1)'(FIFO_DEPTH - 2));
	assign accept = s_axis_tvalid && s_axis_tready;
	assign drain = (row_q >= h_eff);
	assign take = accept && (drain || !s_axis_tuser);
	assign col_last = (WW'(col_q) == w_eff - WW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH: frame_width_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default: frame_width_q <= frame_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q <= col_q;
			px_q <= drain ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
			e0_q <= (row_q != '0) && (col_q != '0);
			e1_q <= (row_q != '0) && col_last;
			lo_skip_q <= (col_q == CW'(1));
			w1_q <= (w_eff == WW'(1));
			top_ok_q <= (row_q > FH_W'(1));
			bot_ok_q <= !drain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (e0_q) begin
						state_q <= ST_EMIT0;
					end else if (e1_q) begin
						state_q <= ST_EMIT1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT0: state_q <= e1_q ? ST_EMIT1 : ST_IDLE;
				ST_EMIT1: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		req = '0;
		req.row_mask = {bot_ok_q, 1'b1, top_ok_q};
		if (state_q == ST_EMIT0) begin
			req.valid = 1'b1;
			req.col_mask = lo_skip_q ? 3'b110 : 3'b111;
			req.run_end = !e1_q;
		end else if (state_q == ST_EMIT1) begin
			req.valid = 1'b1;
			req.col_mask = w1_q ? 3'b100 : 3'b110;
			req.run_end = 1'b1;
			req.frame_end = !bot_ok_q;
		end
	end

	bb3_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(state_q == ST_READ),
		.waddr(addr_q),
		.wdata({ram_rdata[PIX_W-1:0], px_q}),
		.re(take),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	bb3_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.shift_en(state_q == ST_READ),
		.above(ram_rdata[2*PIX_W-1:PIX_W]),
		.mid(ram_rdata[PIX_W-1:0]),
		.px(px_q),
		.req(req),
		.sum_s1(sum_s1)
	);

	bb3_mean u_mean (
		.clk(clk),
		.arst_n(arst_n),
		.sum_s1(sum_s1),
		.res_s2(res_s2)
	);

	bb3_ofifo #(
		.DEPTH(FIFO_DEPTH)
	) u_ofifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_s2),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(out_res),
		.count(q_count)
	);

	assign m_axis_tdata = {out_res.blue, out_res.green, out_res.red};
	assign m_axis_tlast = out_res.run_end;
	assign m_axis_tuser = out_res.frame_end;

endmodule

`default_nettype wire
